// ===== rtl/bks_pkg.sv =====
// Shared types and constants for the bounded key set unit.
package bks_pkg;

    localparam int KEY_W           = 32;
    localparam int KIND_W          = 2;
    localparam int CAP_W           = 5;
    localparam int DEF_MAX_ENTRIES = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes carried in the kind field
    typedef enum logic [KIND_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_QUERY  = 2'd3
    } kind_t;

    // Register indexes on the configuration port
    localparam logic REG_CAPACITY = 1'b0;

    // Per-step control broadcast to every cell
    typedef struct packed {
        logic             load_new;   // successful add: the cell at the count slot loads key
        logic             shift_en;   // remove: cells at or past the match take the neighbor key
        logic [KEY_W-1:0] key;
    } cell_ctrl_t;

endpackage

// ===== rtl/bounded_key_set_unit.sv =====
// Top level of the bounded key set unit: cell chain, count, output register, APB port.
//
// Keeps an ordered set of distinct 32-bit keys in a row of cells. Each input
// transfer (s_kind, s_key) adds, removes, clears or queries one key and yields
// exactly one result transfer (m_ok, m_count): the success or found flag and
// the number of keys held after the step.
// m_valid rises in the cycle after the input transfer. Throughput is one
// item per cycle while the receiver keeps up: every cell compares its key in
// parallel, the first match ripples down the chain, and the matching cell and
// those after it take their neighbor's key in the same cycle.
// The output register holds a result while m_ready is low; s_ready stays high
// as long as that register is empty or being drained, so a stalled receiver
// stalls the input after one item.
// Reset (aresetn low, synchronous) empties the set and sets capacity_limit to
// 16; key cells are not cleared, since only slots below the count are read.
// capacity_limit lives at byte address 0 of the APB port; values above the
// chain depth act as the chain depth. Write it only while the unit is idle.
module bounded_key_set_unit
    import bks_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    // input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [KEY_W-1:0]  s_key,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_ok,
    output logic [CNT_W-1:0]  m_count,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             ok_reg;
    logic             ok_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;

    logic                   accept;
    logic                   cfg_wr;
    logic                   any_match;
    logic                   has_room;
    kind_t                  kind;
    cell_ctrl_t             ctrl;
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES:0]   shift_chain;
    logic [KEY_W-1:0]       cell_key [MAX_ENTRIES];

    assign kind    = kind_t'(s_kind);
    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(32 - CAP_W){1'b0}}, cap_reg} : 32'd0;
    assign cap_next = cfg_wr ? pwdata[CAP_W-1:0] : cap_reg;

    // Lookup result and room check
    assign any_match = |match_vec;
    assign has_room  = (CMP_W'(count_reg) < CMP_W'(cap_reg))
                    && (CMP_W'(count_reg) < CMP_W'(MAX_ENTRIES));

    // Broadcast control to the chain
    always_comb begin
        ctrl.key      = s_key;
        ctrl.load_new = accept && (kind == OP_ADD) && !any_match && has_room;
        ctrl.shift_en = accept && (kind == OP_REMOVE);
    end

    // Cell chain; the first match starts the shift run
    assign shift_chain[0] = 1'b0;
    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        logic [KEY_W-1:0] nbr_key;
        if (i == MAX_ENTRIES - 1) begin : g_last
            assign nbr_key = cell_key[i];
        end else begin : g_mid
            assign nbr_key = cell_key[i+1];
        end
        bks_cell #(
            .CELL_IDX (i),
            .CNT_W    (CNT_W)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .count     (count_reg),
            .nbr_key   (nbr_key),
            .shift_in  (shift_chain[i]),
            .shift_out (shift_chain[i+1]),
            .match     (match_vec[i]),
            .key_out   (cell_key[i])
        );
    end

    // Step result and new count
    always_comb begin
        count_next = count_reg;
        ok_next    = ok_reg;
        if (accept) begin
            case (kind)
                OP_ADD: begin
                    ok_next = !any_match && has_room;
                    if (!any_match && has_room) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_REMOVE: begin
                    ok_next = any_match;
                    if (any_match) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                OP_CLEAR: begin
                    ok_next    = 1'b1;
                    count_next = '0;
                end
                default: begin
                    ok_next = any_match;
                end
            endcase
        end
    end

    // Output register: load on transfer in, drop on transfer out
    always_comb begin
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        if (accept) begin
            out_valid_next = 1'b1;
            out_count_next = count_next;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            cap_reg       <= cap_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg        <= ok_next;
        out_count_reg <= out_count_next;
    end

    assign m_valid = out_valid_reg;
    assign m_ok    = ok_reg;
    assign m_count = out_count_reg;

    // Count never exceeds the chain depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(MAX_ENTRIES))
        else $error("held count above chain depth");

    // A clear reports success and an empty set
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (kind == OP_CLEAR)) |=> (m_valid && m_ok && (m_count == '0)))
        else $error("clear did not report an empty set");

    // Distinct keys: at most one occupied cell matches
    a_single_match: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(match_vec))
        else $error("duplicate key held in set");

    // Reported count follows the internal count
    a_count_echo: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (m_count == count_reg))
        else $error("reported count differs from held count");

endmodule

// ===== rtl/bks_cell.sv =====
// One storage cell of the key chain: holds a key, compares it, shifts from its neighbor.
module bks_cell
    import bks_pkg::*;
#(
    parameter int CELL_IDX = 0,
    parameter int CNT_W    = 5
) (
    input  logic             aclk,
    input  cell_ctrl_t       ctrl,
    input  logic [CNT_W-1:0] count,
    input  logic [KEY_W-1:0] nbr_key,
    input  logic             shift_in,
    output logic             shift_out,
    output logic             match,
    output logic [KEY_W-1:0] key_out
);

    logic [KEY_W-1:0] key_reg;
    logic [KEY_W-1:0] key_next;
    logic             occupied;
    logic             at_tail;

    // Only slots below the count take part in a lookup
    assign occupied  = count > CNT_W'(CELL_IDX);
    assign at_tail   = count == CNT_W'(CELL_IDX);
    assign match     = occupied && (key_reg == ctrl.key);
    assign shift_out = shift_in || match;
    assign key_out   = key_reg;

    // Choose: append at tail, close the gap on remove, or hold
    always_comb begin
        key_next = key_reg;
        if (ctrl.load_new && at_tail) begin
            key_next = ctrl.key;
        end else if (ctrl.shift_en && shift_out) begin
            key_next = nbr_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== tb/bks_result_checker.sv =====
// Checker for the bounded key set unit: tracks the key set and compares every result transfer.
`timescale 1ns / 100ps

module bks_result_checker
    import bks_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [KIND_W-1:0] s_kind,
    input  logic [KEY_W-1:0]  s_key,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_ok,
    input  logic [CNT_W-1:0]  m_count,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic [31:0]       prdata,
    input  logic              pready,
    output int                n_pending,
    output int                n_errors
);

    localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] count;
    } step_result_t;

    // Shadow copy of the set and its capacity register
    logic [KEY_W-1:0] held_keys [DEPTH];
    logic [CNT_W-1:0] held_n = '0;
    logic [CAP_W-1:0] cap_reg = CAP_RESET;
    step_result_t     step_results_q [$];
    int               pend_cnt = 0;
    int               errs = 0;

    assign n_pending = pend_cnt;
    assign n_errors  = errs;

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("%0t: %s mismatch: got %0d, expected %0d", $time, field, got, want);
        errs++;
    endtask

    // Apply one operation to the shadow set and return the result it should give
    function automatic step_result_t apply_set_op(input kind_t op, input logic [KEY_W-1:0] k);
        int hit;
        int room;
        step_result_t res;
        hit = -1;
        for (int i = 0; i < int'(held_n); i++) begin
            if (hit < 0 && held_keys[i] == k) hit = i;
        end
        // capacities past the store depth act as the store depth
        room = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
        res.ok = 1'b0;
        case (op)
            OP_ADD: begin
                if (hit < 0 && int'(held_n) < room) begin
                    held_keys[int'(held_n)] = k;
                    held_n++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    // close the gap left by the removed key
                    for (int i = hit; i + 1 < int'(held_n); i++) held_keys[i] = held_keys[i + 1];
                    held_n--;
                    res.ok = 1'b1;
                end
            end
            OP_CLEAR: begin
                held_n = '0;
                res.ok = 1'b1;
            end
            default: res.ok = (hit >= 0);
        endcase
        res.count = held_n;
        return res;
    endfunction

    // Watch the configuration port and both channels
    always @(posedge aclk) begin
        step_result_t want;
        if (!aresetn) begin
            held_n  = '0;
            cap_reg = CAP_RESET;
            step_results_q.delete();
        end else begin
            if (psel && penable && pready && paddr == CAP_ADDR) begin
                if (pwrite) cap_reg = pwdata[CAP_W-1:0];
                else if (prdata !== 32'(cap_reg))
                    report_mismatch("capacity readback", int'(prdata), int'(cap_reg));
            end
            if (m_valid && m_ready) begin
                if (step_results_q.size() == 0) begin
                    $display("%0t: result transfer with nothing outstanding", $time);
                    errs++;
                end else begin
                    want = step_results_q.pop_front();
                    if (m_ok !== want.ok) report_mismatch("ok", int'(m_ok), int'(want.ok));
                    if (m_count !== want.count)
                        report_mismatch("count", int'(m_count), int'(want.count));
                end
            end
            if (s_valid && s_ready)
                step_results_q.push_back(apply_set_op(kind_t'(s_kind), s_key));
        end
        pend_cnt = step_results_q.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the bounded key set testbench: clock, reset, stimulus, idling and verdict.
`timescale 1ns / 100ps

module tb_top;
    import bks_pkg::*;

    localparam int CNT_W       = $clog2(DEF_MAX_ENTRIES + 1);
    localparam logic [2:0] CAP_ADDR   = {REG_CAPACITY, 2'b00};
    localparam logic [2:0] SPARE_ADDR = 3'd4;  // first slot past the register file
    localparam int PHASES      = 22;
    localparam int PHASE_ITEMS = 75;
    localparam int POOL_SIZE   = 24;
    localparam int QUIET_LIMIT = 2000;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind  = '0;
    logic [KEY_W-1:0]  s_key   = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_ok;
    logic [CNT_W-1:0]  m_count;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    int pending;
    int fail_count;
    int gap_max   = 15;
    int stall_max = 15;
    int quiet     = 0;
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    bounded_key_set_unit dut (.*);

    bks_result_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_kind, .s_key,
        .m_valid, .m_ready, .m_ok, .m_count,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .n_pending(pending), .n_errors(fail_count)
    );

    // Offer one operation after a random gap and hold it until the transfer
    task automatic send_op(input kind_t op, input logic [KEY_W-1:0] k);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= op;
        s_key   <= k;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // One configuration access: setup, access, then idle with psel low
    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Result side: random stalls, with stretches of none
    initial begin
        int stall;
        wait (aresetn);
        forever begin
            stall = $urandom_range(0, stall_max);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // End the run if nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
            if (quiet + 1 >= QUIET_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    initial begin
        int caps_list [6];
        int r;
        logic [KEY_W-1:0] pk;
        caps_list = '{16, 31, 0, 1, 17, 8};

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of the key, duplicates, absent keys, clear
        apb_access(1'b0, CAP_ADDR, '0);
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_ADD, 32'h0000_0000);
        send_op(OP_QUERY, 32'h0000_0000);
        send_op(OP_QUERY, 32'hFFFF_FFFF);
        send_op(OP_QUERY, 32'h1234_5678);
        send_op(OP_REMOVE, 32'h1234_5678);
        send_op(OP_REMOVE, 32'h0000_0000);
        send_op(OP_QUERY, 32'hFFFF_FFFF);
        send_op(OP_CLEAR, 32'hA5A5_A5A5);
        send_op(OP_QUERY, 32'hFFFF_FFFF);
        send_op(OP_REMOVE, 32'hFFFF_FFFF);

        // Zero capacity: adds fail; a write to an unused slot leaves it alone
        settle();
        apb_access(1'b1, CAP_ADDR, 32'd0);
        apb_access(1'b1, SPARE_ADDR, 32'd3);
        apb_access(1'b0, CAP_ADDR, '0);
        send_op(OP_ADD, 32'h5A5A_5A5A);

        // Fill a small set, then lower the capacity below the count
        settle();
        apb_access(1'b1, CAP_ADDR, 32'd3);
        send_op(OP_ADD, 32'h0000_0011);
        send_op(OP_ADD, 32'h0000_0022);
        send_op(OP_ADD, 32'h0000_0033);
        send_op(OP_ADD, 32'h0000_0044);
        settle();
        apb_access(1'b1, CAP_ADDR, 32'd1);
        send_op(OP_ADD, 32'h0000_0044);
        send_op(OP_REMOVE, 32'h0000_0022);
        send_op(OP_ADD, 32'h0000_0055);
        send_op(OP_QUERY, 32'h0000_0033);
        send_op(OP_QUERY, 32'h0000_0022);

        // Random phases: mostly pool keys so the set fills and churns
        for (int p = 0; p < PHASES; p++) begin
            settle();
            apb_access(1'b1, CAP_ADDR, (p < 6) ? caps_list[p] : $urandom_range(0, 31));
            if (p % 2 == 0) apb_access(1'b0, CAP_ADDR, '0);
            gap_max   = (p % 3 == 1) ? 0 : 15;
            stall_max = (p % 4 == 2) ? 0 : 15;
            if (p % 4 == 0) begin
                foreach (key_pool[i]) key_pool[i] = $urandom;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r  = $urandom_range(0, 99);
                pk = key_pool[$urandom_range(0, POOL_SIZE - 1)];
                if (r < 40)      send_op(OP_ADD, pk);
                else if (r < 65) send_op(OP_REMOVE, pk);
                else if (r < 90) send_op(OP_QUERY, pk);
                else if (r < 92) send_op(OP_CLEAR, $urandom);
                else             send_op(kind_t'($urandom_range(0, 3)), $urandom);
            end
        end

        settle();
        repeat (5) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bks_pkg.sv
rtl/bks_cell.sv
rtl/bounded_key_set_unit.sv
tb/bks_result_checker.sv
tb/tb_top.sv
